>>> src/three_axis_stepper_move_sequencer_macros.svh
// Assertion macros used by the sequencer checker.
`ifndef THREE_AXIS_STEPPER_MOVE_SEQUENCER_MACROS_SVH
`define THREE_AXIS_STEPPER_MOVE_SEQUENCER_MACROS_SVH

// same-cycle implication, quiet while in reset
`define TASMS_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, quiet while in reset
`define TASMS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/tasms_pkg.sv
// Shared types and constants of the three-axis stepper move sequencer.
package tasms_pkg;

  localparam int AXES    = 3;
  localparam int MOVES_W = 4;
  localparam int DWELL_W = 16;
  localparam int CFG_W   = 16;
  localparam int ENTRY_W = 16;

  // request modes
  localparam logic [1:0] MODE_STEP  = 2'd0;
  localparam logic [1:0] MODE_MS    = 2'd1;
  localparam logic [1:0] MODE_LOAD  = 2'd2;
  localparam logic [1:0] MODE_START = 2'd3;

  // configuration register indexes
  localparam logic [1:0] REG_MOVES0 = 2'd0;
  localparam logic [1:0] REG_MOVES1 = 2'd1;
  localparam logic [1:0] REG_MOVES2 = 2'd2;
  localparam logic [1:0] REG_DWELL  = 2'd3;

  localparam logic [MOVES_W-1:0] MOVES_RESET = 4'd2;
  localparam logic [DWELL_W-1:0] DWELL_RESET = 16'd1000;

  typedef enum logic [3:0] {
    AX_IDLE   = 4'b0001,
    AX_MOVING = 4'b0010,
    AX_DWELL  = 4'b0100,
    AX_DONE   = 4'b1000
  } axis_state_t;

  // request as it is accepted: drives the table write and read
  typedef struct packed {
    logic               fire;
    logic [1:0]         mode;
    logic [1:0]         axis_sel;
    logic [2:0]         slot;
    logic [ENTRY_W-1:0] steps;
    logic               dir;
  } issue_t;

  // request in the update stage
  typedef struct packed {
    logic       fire;
    logic [1:0] mode;
    logic       phase;
  } lane_ctl_t;

  typedef struct packed {
    logic step;
    logic dir;
    logic en;
    logic done;
  } lane_pins_t;

endpackage

>>> src/tasms_cmd_if.sv
// Request channel of the sequencer.
interface tasms_cmd_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [1:0]  axis_sel;
  logic [2:0]  entry_slot;
  logic [15:0] entry_steps;
  logic        entry_dir;

  modport source (
    output valid, mode, axis_sel, entry_slot, entry_steps, entry_dir,
    input  ready
  );
  modport sink (
    input  valid, mode, axis_sel, entry_slot, entry_steps, entry_dir,
    output ready
  );
endinterface

>>> src/tasms_rsp_if.sv
// Result channel of the sequencer: pin levels after each request.
interface tasms_rsp_if;
  logic       valid;
  logic       ready;
  logic [2:0] step_pins;
  logic [2:0] dir_pins;
  logic [2:0] enable_pins;
  logic       all_done;

  modport source (
    output valid, step_pins, dir_pins, enable_pins, all_done,
    input  ready
  );
  modport sink (
    input  valid, step_pins, dir_pins, enable_pins, all_done,
    output ready
  );
endinterface

>>> src/three_axis_stepper_move_sequencer.sv
// Top level of the three-axis stepper move sequencer.
//
//  channel  direction  handshake          payload
//  cmd      in         valid/ready        mode, axis_sel, entry_slot, entry_steps, entry_dir
//  rsp      out        valid/ready        step_pins, dir_pins, enable_pins, all_done
//  cfg      in         cfg_we, no wait    cfg_index, cfg_data
//
// One request per cycle, sustained. A request first reads the per-axis move table
// RAM, then updates all three lanes and lands in the result register.
// The slot of a retiring request is forwarded to the next table read address.
// Synchronous reset: all motors idle, lane pins low, configuration registers at their reset values.
// A stalled result holds the update stage; further requests wait until it drains.
module three_axis_stepper_move_sequencer #(
  parameter int TABLE_DEPTH = 8,
  parameter int COUNT_BITS  = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  tasms_cmd_if.sink                    cmd,
  tasms_rsp_if.source                  rsp,
  input  logic                         cfg_we,
  input  logic [1:0]                   cfg_index,
  input  logic [tasms_pkg::CFG_W-1:0]  cfg_data
);

  logic [tasms_pkg::MOVES_W-1:0] moves_cfg [tasms_pkg::AXES];
  logic [tasms_pkg::DWELL_W-1:0] dwell_ms;

  logic       s1_valid;
  logic [1:0] s1_mode;
  logic       phase, phase_next;
  logic       out_valid;
  logic [tasms_pkg::AXES-1:0] out_step, out_dir, out_en;
  logic       out_done;

  logic       cmd_fire, s1_fire;
  tasms_pkg::issue_t      issue;
  tasms_pkg::lane_ctl_t   ctl;
  tasms_pkg::lane_pins_t  lane_next [tasms_pkg::AXES];
  logic [tasms_pkg::AXES-1:0] step_next, dir_next, en_next, done_next;

  assign s1_fire   = s1_valid && (!out_valid || rsp.ready);
  assign cmd.ready = !s1_valid || !out_valid || rsp.ready;
  assign cmd_fire  = cmd.valid && cmd.ready;

  assign phase_next = phase ^ (s1_mode == tasms_pkg::MODE_STEP);

  assign issue = '{fire: cmd_fire, mode: cmd.mode, axis_sel: cmd.axis_sel,
                   slot: cmd.entry_slot, steps: cmd.entry_steps, dir: cmd.entry_dir};
  assign ctl   = '{fire: s1_fire, mode: s1_mode, phase: phase_next};

  for (genvar a = 0; a < tasms_pkg::AXES; a++) begin : g_lane
    tasms_axis #(
      .LANE        (a),
      .TABLE_DEPTH (TABLE_DEPTH),
      .COUNT_BITS  (COUNT_BITS)
    ) u_axis (
      .clk       (clk),
      .rst       (rst),
      .issue     (issue),
      .ctl       (ctl),
      .moves     (moves_cfg[a]),
      .dwell_ms  (dwell_ms),
      .pins_next (lane_next[a])
    );
  end

  always_comb begin
    for (int a = 0; a < tasms_pkg::AXES; a++) begin
      step_next[a] = lane_next[a].step;
      dir_next[a]  = lane_next[a].dir;
      en_next[a]   = lane_next[a].en;
      done_next[a] = lane_next[a].done;
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      phase     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd_fire) begin
        s1_valid <= 1'b1;
      end else if (s1_fire) begin
        s1_valid <= 1'b0;
      end
      if (s1_fire) begin
        phase     <= phase_next;
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd_fire) begin
      s1_mode <= cmd.mode;
    end
    if (s1_fire) begin
      out_step <= step_next;
      out_dir  <= dir_next;
      out_en   <= en_next;
      out_done <= &done_next;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int a = 0; a < tasms_pkg::AXES; a++) begin
        moves_cfg[a] <= tasms_pkg::MOVES_RESET;
      end
      dwell_ms <= tasms_pkg::DWELL_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tasms_pkg::REG_MOVES0: moves_cfg[0] <= cfg_data[tasms_pkg::MOVES_W-1:0];
        tasms_pkg::REG_MOVES1: moves_cfg[1] <= cfg_data[tasms_pkg::MOVES_W-1:0];
        tasms_pkg::REG_MOVES2: moves_cfg[2] <= cfg_data[tasms_pkg::MOVES_W-1:0];
        tasms_pkg::REG_DWELL:  dwell_ms     <= cfg_data[tasms_pkg::DWELL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.step_pins   = out_step;
  assign rsp.dir_pins    = out_dir;
  assign rsp.enable_pins = out_en;
  assign rsp.all_done    = out_done;

endmodule

>>> src/tasms_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
module tasms_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> src/tasms_axis.sv
// One motor lane: move table RAM, move state and pin levels of one axis.
module tasms_axis #(
  parameter int LANE        = 0,
  parameter int TABLE_DEPTH = 8,
  parameter int COUNT_BITS  = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  tasms_pkg::issue_t                   issue,
  input  tasms_pkg::lane_ctl_t                ctl,
  input  logic [tasms_pkg::MOVES_W-1:0]       moves,
  input  logic [tasms_pkg::DWELL_W-1:0]       dwell_ms,
  output tasms_pkg::lane_pins_t               pins_next
);

  localparam int SLOT_W = $clog2(TABLE_DEPTH + 1);
  localparam int AW     = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW     = SLOT_W + tasms_pkg::MOVES_W;
  localparam logic [COUNT_BITS-1:0]         COUNT_MAX = '1;
  localparam logic [tasms_pkg::DWELL_W-1:0] DWELL_MAX = '1;

  tasms_pkg::axis_state_t            state, state_next;
  logic [COUNT_BITS-1:0]             steps_done, steps_done_next;
  logic [SLOT_W-1:0]                 slot, slot_next;
  logic [tasms_pkg::DWELL_W-1:0]     dwell_cnt, dwell_cnt_next;
  logic                              step_pin, step_pin_next;
  logic                              dir_pin, dir_pin_next;
  logic                              en_pin, en_pin_next;

  logic                              we, re;
  logic [AW-1:0]                     waddr, raddr;
  logic [COUNT_BITS:0]               wdata, rdata;
  logic [AW+2:0]                     slot_ext;
  logic [COUNT_BITS+tasms_pkg::ENTRY_W-1:0] steps_ext;
  logic [SLOT_W-1:0]                 slot_fwd, slot_inc_fwd, slot_inc;
  logic [CW-1:0]                     moves_ext, count;
  logic [SLOT_W-1:0]                 begin_slot;
  logic                              begin_ok, do_begin;
  logic [COUNT_BITS-1:0]             steps_inc, rd_steps;
  logic                              rd_dir;
  logic [tasms_pkg::DWELL_W-1:0]     dwell_inc;

  // table write at acceptance, so a later request always reads it back
  assign slot_ext  = {{AW{1'b0}}, issue.slot};
  assign steps_ext = {{COUNT_BITS{1'b0}}, issue.steps};
  assign we    = issue.fire && (issue.mode == tasms_pkg::MODE_LOAD)
                 && (issue.axis_sel == 2'(LANE))
                 && ({29'd0, issue.slot} < 32'(TABLE_DEPTH));
  assign waddr = slot_ext[AW-1:0];
  assign wdata = {issue.dir, steps_ext[COUNT_BITS-1:0]};
  assign re    = issue.fire;

  // slot forwarded from the update stage when it retires this cycle
  assign slot_fwd     = ctl.fire ? slot_next : slot;
  assign slot_inc_fwd = slot_fwd + SLOT_W'(1);

  always_comb begin
    unique case (issue.mode) inside
      tasms_pkg::MODE_STEP:                       raddr = slot_fwd[AW-1:0];
      tasms_pkg::MODE_MS:                         raddr = slot_inc_fwd[AW-1:0];
      tasms_pkg::MODE_LOAD, tasms_pkg::MODE_START: raddr = '0;
      default:                                    raddr = '0;
    endcase
  end

  tasms_ram #(
    .WIDTH (COUNT_BITS + 1),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign rd_steps = rdata[COUNT_BITS-1:0];
  assign rd_dir   = rdata[COUNT_BITS];

  // effective move count, saturated to the table depth
  assign moves_ext  = {{SLOT_W{1'b0}}, moves};
  assign count      = (moves_ext > CW'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH) : moves_ext;
  assign slot_inc   = slot + SLOT_W'(1);
  assign begin_slot = (ctl.mode == tasms_pkg::MODE_START) ? '0 : slot_inc;
  assign begin_ok   = {{tasms_pkg::MOVES_W{1'b0}}, begin_slot} < count;

  assign steps_inc = (steps_done == COUNT_MAX) ? steps_done : steps_done + COUNT_BITS'(1);
  assign dwell_inc = (dwell_cnt == DWELL_MAX) ? dwell_cnt
                                              : dwell_cnt + tasms_pkg::DWELL_W'(1);

  always_comb begin
    state_next      = state;
    steps_done_next = steps_done;
    slot_next       = slot;
    dwell_cnt_next  = dwell_cnt;
    step_pin_next   = step_pin;
    dir_pin_next    = dir_pin;
    en_pin_next     = en_pin;
    do_begin        = 1'b0;
    unique case (ctl.mode)
      tasms_pkg::MODE_STEP: begin
        if (state == tasms_pkg::AX_MOVING) begin
          if (ctl.phase) begin
            step_pin_next   = 1'b1;
            steps_done_next = steps_inc;
            if (steps_inc >= rd_steps) begin
              state_next     = tasms_pkg::AX_DWELL;
              dwell_cnt_next = '0;
            end
          end else begin
            step_pin_next = 1'b0;
          end
        end
      end
      tasms_pkg::MODE_MS: begin
        if (state == tasms_pkg::AX_DWELL) begin
          if (dwell_inc >= dwell_ms) begin
            dwell_cnt_next = '0;
            slot_next      = slot_inc;
            do_begin       = 1'b1;
          end else begin
            dwell_cnt_next = dwell_inc;
          end
        end
      end
      tasms_pkg::MODE_LOAD: begin
      end
      tasms_pkg::MODE_START: begin
        slot_next      = '0;
        dwell_cnt_next = '0;
        step_pin_next  = 1'b0;
        en_pin_next    = 1'b0;
        do_begin       = 1'b1;
      end
      default: begin
      end
    endcase
    if (do_begin) begin
      if (begin_ok) begin
        steps_done_next = '0;
        dir_pin_next    = ~rd_dir;
        state_next      = tasms_pkg::AX_MOVING;
      end else begin
        state_next  = tasms_pkg::AX_DONE;
        en_pin_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= tasms_pkg::AX_IDLE;
      steps_done <= '0;
      slot       <= '0;
      dwell_cnt  <= '0;
      step_pin   <= 1'b0;
      dir_pin    <= 1'b0;
      en_pin     <= 1'b0;
    end else if (ctl.fire) begin
      state      <= state_next;
      steps_done <= steps_done_next;
      slot       <= slot_next;
      dwell_cnt  <= dwell_cnt_next;
      step_pin   <= step_pin_next;
      dir_pin    <= dir_pin_next;
      en_pin     <= en_pin_next;
    end
  end

  assign pins_next = '{step: step_pin_next, dir: dir_pin_next, en: en_pin_next,
                       done: (state_next == tasms_pkg::AX_DONE)};

endmodule

>>> src/tasms_chk.sv
// Port-level checker for the sequencer, bound to the top level.
`include "three_axis_stepper_move_sequencer_macros.svh"

module tasms_chk (
  input logic       clk,
  input logic       rst,
  input logic       cmd_valid,
  input logic       cmd_ready,
  input logic       rsp_valid,
  input logic       rsp_ready,
  input logic [2:0] step_pins,
  input logic [2:0] dir_pins,
  input logic [2:0] enable_pins,
  input logic       all_done
);

  // every motor is done exactly when every enable pin is up
  `TASMS_ASSERT(a_done_matches_enable, rsp_valid, all_done == (enable_pins == 3'b111), "all_done disagrees with enable pins")

  // with the result register empty a request is always taken
  `TASMS_ASSERT(a_ready_when_empty, !rsp_valid, cmd_ready, "request refused with no result pending")

  // a stalled result holds
  `TASMS_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable({step_pins, dir_pins, enable_pins, all_done}), "stalled result changed")

endmodule

bind three_axis_stepper_move_sequencer tasms_chk u_chk (
  .clk         (clk),
  .rst         (rst),
  .cmd_valid   (cmd.valid),
  .cmd_ready   (cmd.ready),
  .rsp_valid   (rsp.valid),
  .rsp_ready   (rsp.ready),
  .step_pins   (rsp.step_pins),
  .dir_pins    (rsp.dir_pins),
  .enable_pins (rsp.enable_pins),
  .all_done    (rsp.all_done)
);
